// ===== hw/rtl/bsm_pkg.sv =====
// Shared types, codes and constants of the bank switch mapper.
package bsm_pkg;

  // Operation codes carried on the input tuser field.
  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_PRG   = 2'd1,
    OP_PAT   = 2'd2,
    OP_TICK  = 2'd3
  } op_t;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    CFG_BANK_COUNT   = 1'b0,
    CFG_RESET_MIRROR = 1'b1
  } cfg_idx_t;

  localparam int unsigned ADDR_W   = 16;
  localparam int unsigned DATA_W   = 8;
  localparam int unsigned MAP_W    = 21;
  localparam int unsigned CFG_W    = 8;
  localparam int unsigned IN_TDATA_W  = 24;
  localparam int unsigned OUT_TDATA_W = 24;

  // Register window selects, taken from address bits 15..13.
  localparam logic [2:0] WIN_BANK   = 3'b100;
  localparam logic [2:0] WIN_MIRROR = 3'b101;
  localparam logic [2:0] WIN_IRQ    = 3'b110;
  localparam logic [2:0] WIN_ENABLE = 3'b111;

  // Bank select codes 6 and 7 address the two program banks.
  localparam logic [2:0] SEL_PRG0 = 3'd6;

  // One input item as held in the input stage.
  typedef struct packed {
    op_t                 op;
    logic [ADDR_W-1:0]   addr;
    logic [DATA_W-1:0]   data;
  } item_t;

  // Bank setup seen by the address translator.
  typedef struct packed {
    logic [7:0]       bank_count;
    logic             prg_swap;
    logic             pat_invert;
    logic [5:0][7:0]  pattern_bank;
    logic [1:0][7:0]  program_bank;
  } map_state_t;

  // Status after the current item.
  typedef struct packed {
    logic irq_pending;
    logic mirror_horizontal;
  } status_t;

endpackage

// ===== hw/rtl/bsm_regs.sv =====
// Mapper register file, mirroring control and scanline interrupt counter.
module bsm_regs (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  bsm_pkg::cfg_idx_t         cfg_index,
  input  logic [bsm_pkg::CFG_W-1:0] cfg_wdata,
  input  logic                      item_go,
  input  bsm_pkg::item_t            item,
  output bsm_pkg::map_state_t       map_state,
  output bsm_pkg::status_t          status_nxt
);

  logic [7:0]      bank_count_r, bank_count_nxt;
  logic [2:0]      bank_sel_r, bank_sel_nxt;
  logic            prg_swap_r, prg_swap_nxt;
  logic            pat_invert_r, pat_invert_nxt;
  logic [5:0][7:0] pattern_bank_r, pattern_bank_nxt;
  logic [1:0][7:0] program_bank_r, program_bank_nxt;
  logic            mirror_r, mirror_nxt;
  logic [7:0]      latch_r, latch_nxt;
  logic [7:0]      counter_r, counter_nxt;
  logic            irq_en_r, irq_en_nxt;
  logic            irq_flag_r, irq_flag_nxt;
  logic            odd;
  logic [2:0]      win;

  assign odd = item.addr[0];
  assign win = item.addr[15:13];

  // Next state from configuration writes and the current request.
  always_comb begin
    bank_count_nxt   = bank_count_r;
    bank_sel_nxt     = bank_sel_r;
    prg_swap_nxt     = prg_swap_r;
    pat_invert_nxt   = pat_invert_r;
    pattern_bank_nxt = pattern_bank_r;
    program_bank_nxt = program_bank_r;
    mirror_nxt       = mirror_r;
    latch_nxt        = latch_r;
    counter_nxt      = counter_r;
    irq_en_nxt       = irq_en_r;
    irq_flag_nxt     = irq_flag_r;
    if (cfg_we) begin
      unique case (cfg_index)
        bsm_pkg::CFG_BANK_COUNT:   bank_count_nxt = cfg_wdata;
        bsm_pkg::CFG_RESET_MIRROR: mirror_nxt     = cfg_wdata[0];
        default: ;
      endcase
    end
    if (item_go) begin
      unique case (item.op)
        bsm_pkg::OP_WRITE: begin
          unique case (win)
            bsm_pkg::WIN_BANK: begin
              if (!odd) begin
                bank_sel_nxt   = item.data[2:0];
                prg_swap_nxt   = item.data[6];
                pat_invert_nxt = item.data[7];
              end else if (bank_sel_r < bsm_pkg::SEL_PRG0) begin
                pattern_bank_nxt[bank_sel_r] = item.data;
              end else begin
                program_bank_nxt[bank_sel_r[0]] = item.data;
              end
            end
            bsm_pkg::WIN_MIRROR: begin
              if (!odd) mirror_nxt = item.data[0];
            end
            bsm_pkg::WIN_IRQ: begin
              if (!odd) latch_nxt = item.data;
              else      counter_nxt = latch_r;
            end
            bsm_pkg::WIN_ENABLE: begin
              if (!odd) begin
                irq_en_nxt   = 1'b0;
                irq_flag_nxt = 1'b0;
              end else begin
                irq_en_nxt = 1'b1;
              end
            end
            default: ;
          endcase
        end
        bsm_pkg::OP_TICK: begin
          // Reload at zero, otherwise count down; flag when the count lands on zero with interrupts enabled.
          if (counter_r == 8'd0) counter_nxt = latch_r;
          else                   counter_nxt = counter_r - 8'd1;
          if ((counter_nxt == 8'd0) && irq_en_r) irq_flag_nxt = 1'b1;
        end
        default: ;
      endcase
    end
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bank_count_r   <= 8'd2;
      bank_sel_r     <= '0;
      prg_swap_r     <= 1'b0;
      pat_invert_r   <= 1'b0;
      pattern_bank_r <= '0;
      program_bank_r <= '0;
      mirror_r       <= 1'b0;
      latch_r        <= '0;
      counter_r      <= '0;
      irq_en_r       <= 1'b0;
      irq_flag_r     <= 1'b0;
    end else begin
      bank_count_r   <= bank_count_nxt;
      bank_sel_r     <= bank_sel_nxt;
      prg_swap_r     <= prg_swap_nxt;
      pat_invert_r   <= pat_invert_nxt;
      pattern_bank_r <= pattern_bank_nxt;
      program_bank_r <= program_bank_nxt;
      mirror_r       <= mirror_nxt;
      latch_r        <= latch_nxt;
      counter_r      <= counter_nxt;
      irq_en_r       <= irq_en_nxt;
      irq_flag_r     <= irq_flag_nxt;
    end
  end

  // Translation uses the setup in force before the current request.
  assign map_state.bank_count   = bank_count_r;
  assign map_state.prg_swap     = prg_swap_r;
  assign map_state.pat_invert   = pat_invert_r;
  assign map_state.pattern_bank = pattern_bank_r;
  assign map_state.program_bank = program_bank_r;

  assign status_nxt.irq_pending       = irq_flag_nxt;
  assign status_nxt.mirror_horizontal = mirror_nxt;

`ifndef ASSERT_OFF
  // The interrupt flag is only raised by a scanline tick.
  a_irq_from_tick: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(irq_flag_r) |-> $past(item_go && (item.op == bsm_pkg::OP_TICK)))
    else $error("irq flag set without a tick");
  // The interrupt flag never rises while interrupts are disabled.
  a_irq_needs_enable: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(irq_flag_r) |-> $past(irq_en_r))
    else $error("irq flag set while disabled");
`endif

endmodule

// ===== hw/rtl/bsm_xlate.sv =====
// Program and pattern address translation for one request.
module bsm_xlate (
  input  bsm_pkg::item_t                 item,
  input  bsm_pkg::map_state_t            map_state,
  output logic [bsm_pkg::MAP_W-1:0]      mapped_addr,
  output logic                           mapped_valid
);

  logic [7:0] dbl;
  logic [7:0] last_bank;
  logic [7:0] second_last;
  logic [1:0] slot;
  logic [7:0] window_bank;
  logic       p12;
  logic [7:0] wide_bank;
  logic [7:0] small_bank;

  // Fixed banks follow from the 16 KB bank count, wrapped to 8 bits.
  assign dbl         = {map_state.bank_count[6:0], 1'b0};
  assign last_bank   = dbl - 8'd1;
  assign second_last = dbl - 8'd2;

  // Program window select.
  assign slot = item.addr[14:13];
  always_comb begin
    if (slot == 2'd3) begin
      window_bank = last_bank;
    end else if (slot == 2'd1) begin
      window_bank = map_state.program_bank[1];
    end else if ((slot == 2'd0) != map_state.prg_swap) begin
      window_bank = map_state.program_bank[0];
    end else begin
      window_bank = second_last;
    end
  end

  // Pattern window select; inversion swaps the 4 KB halves.
  assign p12        = item.addr[12] ^ map_state.pat_invert;
  assign wide_bank  = map_state.pattern_bank[{2'b00, item.addr[11]}];
  assign small_bank = map_state.pattern_bank[3'd2 + {1'b0, item.addr[11:10]}];

  always_comb begin
    mapped_addr  = '0;
    mapped_valid = 1'b0;
    unique case (item.op)
      bsm_pkg::OP_PRG: begin
        if (item.addr[15]) begin
          mapped_addr  = {window_bank, item.addr[12:0]};
          mapped_valid = 1'b1;
        end
      end
      bsm_pkg::OP_PAT: begin
        if (item.addr[15:13] == 3'b000) begin
          if (!p12) mapped_addr = {3'b000, wide_bank[7:1], item.addr[10:0]};
          else      mapped_addr = {3'b000, small_bank, item.addr[9:0]};
          mapped_valid = 1'b1;
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== hw/rtl/bank_switch_mapper_with_scanline_irq.sv =====
// Top level of the bank switch mapper with scanline interrupt counter.
//
// Usage: each request on the in_ stream carries an operation in in_tuser
// (register write, program map, pattern map or scanline tick), and the bus
// address and write byte in in_tdata. Every request yields exactly one
// response on the out_ stream with the translated ROM offset, a hit flag in
// out_tuser, the interrupt request line and the current mirroring.
// A request is registered in the input register, then translation and state
// update load the output register. Throughput is one request per clock while
// the receiver does not stall; the single-pass logic between the two registers
// sets that figure. When the receiver stalls the output register holds its
// response, the input register keeps one more request, and in_tready falls
// once both are full.
// The cfg_ port writes the bank count and the reset mirroring; the user must
// use it only while no request is in flight, and the block itself does not
// enforce this. A synchronous reset on rst_n empties both stages and returns
// all mapper state to its reset values (bank count two, vertical mirroring,
// interrupts off).
module bank_switch_mapper_with_scanline_irq (
  input  logic                            clk,
  input  logic                            rst_n,
  // Configuration write port.
  input  logic                            cfg_we,
  input  logic [0:0]                      cfg_index,
  input  logic [bsm_pkg::CFG_W-1:0]       cfg_wdata,
  // Request stream.
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [bsm_pkg::IN_TDATA_W-1:0]  in_tdata,   // addr[15:0], data[23:16]
  input  logic [1:0]                      in_tuser,   // op[1:0]
  // Response stream.
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [bsm_pkg::OUT_TDATA_W-1:0] out_tdata,  // mapped_addr[20:0],
                                                      // irq_pending[21],
                                                      // mirror_horizontal[22],
                                                      // zero[23]
  output logic [0:0]                      out_tuser   // mapped_valid[0]
);

  bsm_pkg::item_t       s1_item_r;
  logic                 s1_valid_r, s1_valid_nxt;
  logic                 out_free;
  logic                 s1_go;
  logic                 in_go;
  bsm_pkg::map_state_t  map_state;
  bsm_pkg::status_t     status_nxt;
  logic [bsm_pkg::MAP_W-1:0] mapped_addr;
  logic                 mapped_valid;
  logic [bsm_pkg::MAP_W-1:0] out_addr_r;
  logic                 out_hit_r;
  logic                 out_irq_r;
  logic                 out_mirror_r;
  logic                 out_valid_r, out_valid_nxt;

  // Handshake control of the two stages.
  assign out_free  = !out_valid_r || out_tready;
  assign s1_go     = s1_valid_r && out_free;
  assign in_tready = !s1_valid_r || out_free;
  assign in_go     = in_tvalid && in_tready;

  assign s1_valid_nxt  = in_go || (s1_valid_r && !out_free);
  assign out_valid_nxt = s1_go || (out_valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (in_go) begin
      s1_item_r.op   <= bsm_pkg::op_t'(in_tuser);
      s1_item_r.addr <= in_tdata[15:0];
      s1_item_r.data <= in_tdata[23:16];
    end
  end

  bsm_regs u_regs (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (bsm_pkg::cfg_idx_t'(cfg_index)),
    .cfg_wdata  (cfg_wdata),
    .item_go    (s1_go),
    .item       (s1_item_r),
    .map_state  (map_state),
    .status_nxt (status_nxt)
  );

  bsm_xlate u_xlate (
    .item         (s1_item_r),
    .map_state    (map_state),
    .mapped_addr  (mapped_addr),
    .mapped_valid (mapped_valid)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (s1_go) begin
      out_addr_r   <= mapped_addr;
      out_hit_r    <= mapped_valid;
      out_irq_r    <= status_nxt.irq_pending;
      out_mirror_r <= status_nxt.mirror_horizontal;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_mirror_r, out_irq_r, out_addr_r};
  assign out_tuser  = out_hit_r;

`ifndef ASSERT_OFF
  // A miss or a non-map response carries a zero offset.
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_hit_r) |-> (out_addr_r == '0))
    else $error("nonzero offset on a miss");
  // A request held in the input stage stays there while the output is blocked.
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !out_free) |=> (s1_valid_r && $stable(s1_item_r)))
    else $error("input stage lost a request");
  // An empty input stage always takes a request.
  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |-> in_tready)
    else $error("ready low with empty input stage");
  // A request that advances always lands in the output register.
  a_advance: assert property (@(posedge clk) disable iff (!rst_n)
    s1_go |=> out_valid_r)
    else $error("advanced request not presented");
`endif

endmodule

// ===== test/mapper_checker.sv =====
// Checker for the bank switch mapper: predicts each response and compares it field by field.
module mapper_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [7:0]  cfg_wdata,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [23:0] in_tdata,   // addr[15:0], data[23:16]
  input  logic [1:0]  in_tuser,   // op[1:0]
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [23:0] out_tdata,  // mapped_addr[20:0], irq_pending[21],
                                  // mirror_horizontal[22], zero[23]
  input  logic [0:0]  out_tuser,  // mapped_valid[0]
  output int          awaiting,
  output int          mismatches
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [bsm_pkg::MAP_W-1:0] mapped_addr;
    logic                      mapped_valid;
    logic                      irq_pending;
    logic                      mirror_horizontal;
  } mapper_response_t;

  // Shadow copy of the mapper state and its configuration.
  logic [7:0] bank_count;
  logic [2:0] bank_index;
  logic       prg_swap;
  logic       pat_invert;
  logic [7:0] pattern_bank [6];
  logic [7:0] program_bank [2];
  logic       mirror_h;
  logic [7:0] count_reload;
  logic [7:0] line_counter;
  logic       irq_armed;
  logic       irq_line;

  mapper_response_t predicted_responses [$];

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t ns: %s is 0x%0h, predicted 0x%0h", $time, what, got, want);
    mismatches++;
  endtask

  // Bank behind one of the four 8 KB program windows. The top window is always
  // the last bank; the swap mode exchanges the first and third windows.
  function automatic logic [7:0] program_window_bank(logic [1:0] slot);
    logic [7:0] doubled;
    doubled = {bank_count[6:0], 1'b0};
    if (slot == 2'd3)
      return doubled - 8'd1;
    if (slot == 2'd1)
      return program_bank[1];
    if ((slot == 2'd0) != prg_swap)
      return program_bank[0];
    return doubled - 8'd2;
  endfunction

  // CPU writes into the register windows; anything below the program space is dropped.
  function automatic void apply_register_write(logic [15:0] addr, logic [7:0] data);
    if (!addr[15])
      return;
    case (addr[15:13])
      bsm_pkg::WIN_BANK: begin
        if (!addr[0]) begin
          bank_index = data[2:0];
          prg_swap   = data[6];
          pat_invert = data[7];
        end else if (bank_index < bsm_pkg::SEL_PRG0) begin
          pattern_bank[bank_index] = data;
        end else begin
          program_bank[bank_index[0]] = data;
        end
      end
      bsm_pkg::WIN_MIRROR: begin
        if (!addr[0])
          mirror_h = data[0];
      end
      bsm_pkg::WIN_IRQ: begin
        if (!addr[0])
          count_reload = data;
        else
          line_counter = count_reload;
      end
      bsm_pkg::WIN_ENABLE: begin
        if (!addr[0]) begin
          irq_armed = 1'b0;
          irq_line  = 1'b0;
        end else begin
          irq_armed = 1'b1;
        end
      end
      default: ;
    endcase
  endfunction

  // Works out the response to one request and advances the shadow state.
  function automatic mapper_response_t predict_response(bsm_pkg::op_t op,
                                                        logic [15:0] addr,
                                                        logic [7:0] data);
    mapper_response_t resp;
    logic [12:0]      pos;
    logic [7:0]       bank;
    resp = '0;
    case (op)
      bsm_pkg::OP_WRITE: apply_register_write(addr, data);
      bsm_pkg::OP_PRG: begin
        if (addr[15]) begin
          resp.mapped_addr  = {program_window_bank(addr[14:13]), addr[12:0]};
          resp.mapped_valid = 1'b1;
        end
      end
      bsm_pkg::OP_PAT: begin
        if (addr[15:13] == 3'd0) begin
          // Inversion swaps the 4 KB halves of 2 KB windows and of 1 KB windows.
          pos = addr[12:0] ^ {pat_invert, 12'd0};
          if (!pos[12]) begin
            // The 2 KB windows ignore the low bit of their bank number.
            bank = pattern_bank[pos[11]] & 8'hFE;
            resp.mapped_addr = (bsm_pkg::MAP_W'(bank) << 10) | bsm_pkg::MAP_W'(addr[10:0]);
          end else begin
            bank = pattern_bank[3'd2 + {1'b0, pos[11:10]}];
            resp.mapped_addr = (bsm_pkg::MAP_W'(bank) << 10) | bsm_pkg::MAP_W'(addr[9:0]);
          end
          resp.mapped_valid = 1'b1;
        end
      end
      bsm_pkg::OP_TICK: begin
        line_counter = (line_counter == 8'd0) ? count_reload : line_counter - 8'd1;
        if (line_counter == 8'd0 && irq_armed)
          irq_line = 1'b1;
      end
    endcase
    resp.irq_pending       = irq_line;
    resp.mirror_horizontal = mirror_h;
    return resp;
  endfunction

  // Track configuration, predict on each accepted request, compare each response.
  always @(posedge clk) begin
    mapper_response_t want;
    if (!rst_n) begin
      bank_count   = 8'd2;
      bank_index   = '0;
      prg_swap     = 1'b0;
      pat_invert   = 1'b0;
      for (int i = 0; i < 6; i++)
        pattern_bank[i] = '0;
      program_bank[0] = '0;
      program_bank[1] = '0;
      mirror_h     = 1'b0;
      count_reload = '0;
      line_counter = '0;
      irq_armed    = 1'b0;
      irq_line     = 1'b0;
      predicted_responses.delete();
    end else begin
      if (cfg_we) begin
        case (bsm_pkg::cfg_idx_t'(cfg_index))
          bsm_pkg::CFG_BANK_COUNT:   bank_count = cfg_wdata;
          bsm_pkg::CFG_RESET_MIRROR: mirror_h = cfg_wdata[0];
        endcase
      end
      if (out_tvalid && out_tready) begin
        if (predicted_responses.size() == 0) begin
          report_mismatch("response without a request, out_tdata", 32'(out_tdata), 32'd0);
        end else begin
          want = predicted_responses.pop_front();
          if (out_tdata[20:0] !== want.mapped_addr)
            report_mismatch("mapped_addr", 32'(out_tdata[20:0]), 32'(want.mapped_addr));
          if (out_tuser[0] !== want.mapped_valid)
            report_mismatch("mapped_valid", 32'(out_tuser[0]), 32'(want.mapped_valid));
          if (out_tdata[21] !== want.irq_pending)
            report_mismatch("irq_pending", 32'(out_tdata[21]), 32'(want.irq_pending));
          if (out_tdata[22] !== want.mirror_horizontal)
            report_mismatch("mirror_horizontal", 32'(out_tdata[22]),
                            32'(want.mirror_horizontal));
        end
      end
      if (in_tvalid && in_tready)
        predicted_responses.push_back(
          predict_response(bsm_pkg::op_t'(in_tuser), in_tdata[15:0], in_tdata[23:16]));
    end
    awaiting <= predicted_responses.size();
  end

endmodule

// ===== test/testbench.sv =====
// Regression top for the bank switch mapper: clock, reset, request traffic and verdict.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RANDOM_REQUESTS = 1300;
  localparam int unsigned PHASES          = 6;
  localparam int unsigned QUIET_LIMIT     = 1000;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        cfg_we     = 1'b0;
  logic [0:0]  cfg_index  = '0;
  logic [7:0]  cfg_wdata  = '0;
  logic        in_tvalid  = 1'b0;
  logic [23:0] in_tdata   = '0;
  logic [1:0]  in_tuser   = '0;
  logic        out_tready = 1'b0;
  logic        in_tready;
  logic        out_tvalid;
  logic [23:0] out_tdata;
  logic [0:0]  out_tuser;

  int          awaiting;
  int          mismatches;
  bit          steady        = 1'b0;
  int unsigned requests_sent = 0;
  int unsigned quiet_cycles  = 0;
  int unsigned stall_left    = 0;

  bank_switch_mapper_with_scanline_irq u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  mapper_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .awaiting   (awaiting),
    .mismatches (mismatches)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver back-pressure: random stalls, none in the final phase.
  always @(posedge clk) begin
    if (!rst_n || steady) begin
      out_tready <= 1'b1;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      out_tready <= (stall_left == 1);
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 7) == 0) begin
      out_tready <= 1'b0;
      stall_left <= $urandom_range(1, 5);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Watchdog: too long without any handshake means the block is stuck.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("bank_switch_mapper_with_scanline_irq regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offers one request and returns at the edge where it is taken.
  task automatic send_request(bsm_pkg::op_t op, logic [15:0] addr, logic [7:0] data);
    if (!steady && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {data, addr};
    do @(posedge clk); while (!in_tready);
    requests_sent++;
  endtask

  // Stops traffic and waits until every predicted response has come back.
  task automatic settle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (awaiting != 0);
    repeat (4) @(posedge clk);
  endtask

  // Drives one register write for a cycle; the caller drops the enable after its last write.
  task automatic write_config(bsm_pkg::cfg_idx_t idx, logic [7:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
  endtask

  // Random address inside one 8 KB register window, with the low bit chosen.
  function automatic logic [15:0] window_addr(logic [2:0] win, logic odd);
    logic [15:0] bits;
    bits = 16'($urandom);
    return {win, bits[12:1], odd};
  endfunction

  // Mostly addresses inside the translated space, now and then anywhere.
  function automatic logic [15:0] map_addr(bsm_pkg::op_t op);
    logic [15:0] bits;
    bits = 16'($urandom);
    if ($urandom_range(0, 7) == 0)
      return bits;
    return (op == bsm_pkg::OP_PRG) ? {1'b1, bits[14:0]} : {3'b000, bits[12:0]};
  endfunction

  // One short burst of related requests with random content.
  task automatic random_sequence();
    int unsigned  count;
    bsm_pkg::op_t op;
    logic [7:0]   latch;
    case ($urandom_range(0, 9))
      0, 1: begin
        // Bank select followed by a bank load, then some lookups.
        send_request(bsm_pkg::OP_WRITE, window_addr(bsm_pkg::WIN_BANK, 1'b0), 8'($urandom));
        send_request(bsm_pkg::OP_WRITE, window_addr(bsm_pkg::WIN_BANK, 1'b1), 8'($urandom));
        count = $urandom_range(1, 4);
        repeat (count) begin
          op = ($urandom_range(0, 1) != 0) ? bsm_pkg::OP_PRG : bsm_pkg::OP_PAT;
          send_request(op, map_addr(op), 8'($urandom));
        end
      end
      2: send_request(bsm_pkg::OP_WRITE, window_addr(bsm_pkg::WIN_MIRROR, 1'($urandom)),
                      8'($urandom));
      3, 4: begin
        // Program the scanline counter, then run lines through it.
        latch = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 6));
        send_request(bsm_pkg::OP_WRITE, window_addr(bsm_pkg::WIN_IRQ, 1'b0), latch);
        if ($urandom_range(0, 2) != 0)
          send_request(bsm_pkg::OP_WRITE, window_addr(bsm_pkg::WIN_IRQ, 1'b1), 8'($urandom));
        send_request(bsm_pkg::OP_WRITE,
                     window_addr(bsm_pkg::WIN_ENABLE, $urandom_range(0, 3) != 0),
                     8'($urandom));
        count = $urandom_range(1, 12);
        repeat (count) begin
          if ($urandom_range(0, 9) == 0)
            send_request(bsm_pkg::OP_WRITE,
                         window_addr(bsm_pkg::WIN_ENABLE, 1'($urandom)), 8'($urandom));
          else
            send_request(bsm_pkg::OP_TICK, 16'($urandom), 8'($urandom));
        end
      end
      5, 6: begin
        count = $urandom_range(1, 6);
        repeat (count)
          send_request(bsm_pkg::OP_PRG, map_addr(bsm_pkg::OP_PRG), 8'($urandom));
      end
      7, 8: begin
        count = $urandom_range(1, 6);
        repeat (count)
          send_request(bsm_pkg::OP_PAT, map_addr(bsm_pkg::OP_PAT), 8'($urandom));
      end
      default: send_request(bsm_pkg::op_t'($urandom_range(0, 3)), 16'($urandom),
                            8'($urandom));
    endcase
  endtask

  initial begin
    int unsigned goal;
    logic [7:0]  bank_setting;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed requests under the reset configuration.
    send_request(bsm_pkg::OP_PRG, 16'h8000, 8'h00);
    send_request(bsm_pkg::OP_PRG, 16'hFFFF, 8'hFF);
    send_request(bsm_pkg::OP_PRG, 16'h7FFF, 8'h00);
    send_request(bsm_pkg::OP_PAT, 16'h0000, 8'h00);
    send_request(bsm_pkg::OP_PAT, 16'h1FFF, 8'h00);
    send_request(bsm_pkg::OP_PAT, 16'h2000, 8'h00);
    // A write below the register space must leave everything alone.
    send_request(bsm_pkg::OP_WRITE, 16'h7FFF, 8'hFF);
    send_request(bsm_pkg::OP_WRITE, 16'h8000, 8'hC7);
    send_request(bsm_pkg::OP_WRITE, 16'h8001, 8'hFF);
    send_request(bsm_pkg::OP_WRITE, 16'h9FFE, 8'h06);
    send_request(bsm_pkg::OP_WRITE, 16'h9FFF, 8'h81);
    send_request(bsm_pkg::OP_WRITE, 16'h8000, 8'h00);
    // An odd bank number in a 2 KB window.
    send_request(bsm_pkg::OP_WRITE, 16'h8001, 8'hFF);
    send_request(bsm_pkg::OP_PRG, 16'hA000, 8'h00);
    send_request(bsm_pkg::OP_PRG, 16'h8000, 8'h00);
    send_request(bsm_pkg::OP_PAT, 16'h07FF, 8'h00);
    // Swapped program windows and inverted pattern halves.
    send_request(bsm_pkg::OP_WRITE, 16'h8000, 8'hC0);
    send_request(bsm_pkg::OP_PRG, 16'hC000, 8'h00);
    send_request(bsm_pkg::OP_PAT, 16'h1000, 8'h00);
    send_request(bsm_pkg::OP_WRITE, 16'hA000, 8'h01);
    // Counter reaches zero with interrupts on, then a disable clears the line.
    send_request(bsm_pkg::OP_WRITE, 16'hC000, 8'h01);
    send_request(bsm_pkg::OP_WRITE, 16'hC001, 8'h00);
    send_request(bsm_pkg::OP_WRITE, 16'hE001, 8'h00);
    send_request(bsm_pkg::OP_TICK, 16'h0000, 8'h00);
    send_request(bsm_pkg::OP_WRITE, 16'hE000, 8'h00);
    send_request(bsm_pkg::OP_TICK, 16'hFFFF, 8'hFF);
    send_request(bsm_pkg::OP_PAT, 16'hFFFF, 8'hFF);

    // Random phases, each under its own configuration; the last one runs without idling.
    for (int phase = 0; phase < PHASES; phase++) begin
      settle();
      case (phase)
        0:       bank_setting = 8'd1;
        1:       bank_setting = 8'd128;
        2:       bank_setting = 8'd0;
        3:       bank_setting = 8'd255;
        4:       bank_setting = 8'($urandom_range(1, 128));
        default: bank_setting = 8'd2;
      endcase
      write_config(bsm_pkg::CFG_BANK_COUNT, bank_setting);
      write_config(bsm_pkg::CFG_RESET_MIRROR, {7'd0, ~phase[0]});
      cfg_we <= 1'b0;
      if (phase == PHASES - 1)
        steady <= 1'b1;
      goal = requests_sent + RANDOM_REQUESTS / PHASES;
      while (requests_sent < goal)
        random_sequence();
    end

    settle();
    if (mismatches == 0)
      $display("bank_switch_mapper_with_scanline_irq regression: pass");
    else
      $display("bank_switch_mapper_with_scanline_irq regression: fail");
    $finish;
  end

endmodule
